// ===== rtl/core/affine_transform_matrix_builder_assert.svh =====
`ifndef AFFINE_TRANSFORM_MATRIX_BUILDER_ASSERT_SVH
`define AFFINE_TRANSFORM_MATRIX_BUILDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ATMB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atmb same-cycle check failed");

// Next-cycle implication.
`define ATMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atmb next-cycle check failed");

`endif

// ===== rtl/core/atmb_pkg.sv =====
`timescale 1ns / 1ps
package atmb_pkg;

  localparam int QW = 34;   // Q.30 working width
  localparam int SW = 16;   // scale width
  localparam int DW = 29;   // quotient width of the divider chain

  typedef logic signed [QW-1:0] q30_t;

  localparam q30_t              GAIN_Q30    = 34'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [31:0]        ONE_Q16     = 32'd65536;
  localparam logic [31:0]        SAT_POS     = 32'h7fff_ffff;
  localparam logic [31:0]        SAT_NEG     = 32'h8000_0000;
  localparam logic [1:0]         ROW_LAST    = 2'd3;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543515,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // Payload that rides along the CORDIC cells.
  typedef struct packed {
    logic                  opcode;
    logic [2:0][SW-1:0]    sc;
    logic [2:0][31:0]      sh;
    logic [2:0]            neg;
  } cpay_t;

  // Payload that rides along the divider cells.
  typedef struct packed {
    logic                  dir;
    logic [2:0][31:0]      sh;
    logic [8:0][31:0]      pos;
    logic [8:0]            sgn;
    logic [8:0]            rneg;
    logic [2:0]            szero;
  } dpay_t;

  // Q.30 product, rounded half up.
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + 68'sd536870912;
    return p[QW+29:30];
  endfunction

endpackage

// ===== rtl/core/atmb_cordic_cell.sv =====
`timescale 1ns / 1ps
module atmb_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  atmb_pkg::q30_t x_i,
  input  atmb_pkg::q30_t y_i,
  input  atmb_pkg::q30_t z_i,
  output atmb_pkg::q30_t x_o,
  output atmb_pkg::q30_t y_o,
  output atmb_pkg::q30_t z_o
);
  import atmb_pkg::*;

  localparam q30_t ATAN = q30_t'({4'b0, ATAN_TAB[STEP]});

  q30_t dx, dy;
  q30_t x_d, y_d, z_d;
  q30_t x_q, y_q, z_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (z_i >= 0) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// ===== rtl/core/atmb_div_cell.sv =====
`timescale 1ns / 1ps
module atmb_div_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [atmb_pkg::SW-1:0]    rem_i,
  input  logic [atmb_pkg::DW-1:0]    w_i,
  input  logic [atmb_pkg::SW-1:0]    d_i,
  output logic [atmb_pkg::SW-1:0]    rem_o,
  output logic [atmb_pkg::DW-1:0]    w_o,
  output logic [atmb_pkg::SW-1:0]    d_o
);
  import atmb_pkg::*;

  logic [SW:0]   t;
  logic          ge;
  logic [SW-1:0] rem_d, rem_q, d_q;
  logic [DW-1:0] w_d, w_q;

  // One restoring step: numerator bits leave at the top, quotient bits enter below.
  always_comb begin
    t     = {rem_i, w_i[DW-1]};
    ge    = t >= {1'b0, d_i};
    rem_d = ge ? SW'(t - {1'b0, d_i}) : t[SW-1:0];
    w_d   = {w_i[DW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      w_q   <= w_d;
      d_q   <= d_i;
    end
  end

  assign rem_o = rem_q;
  assign w_o   = w_q;
  assign d_o   = d_q;
endmodule

// ===== rtl/core/atmb_rot.sv =====
`timescale 1ns / 1ps
module atmb_rot (
  input  logic           clk_i,
  input  logic           en_i,
  input  atmb_pkg::q30_t sin_i [3],
  input  atmb_pkg::q30_t cos_i [3],
  output atmb_pkg::q30_t rot_o [9]
);
  import atmb_pkg::*;

  q30_t sxsy_q, cxsy_q, r00_q, r10_q, r21_q, r22_q;
  q30_t cxsz_q, sxsz_q, cxcz_q, sxcz_q, cz_q, sz_q, r20_q;
  q30_t rot_q [9];

  // first products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxsy_q <= mul30(sin_i[0], sin_i[1]);
      cxsy_q <= mul30(cos_i[0], sin_i[1]);
      r00_q  <= mul30(cos_i[1], cos_i[2]);
      r10_q  <= mul30(cos_i[1], sin_i[2]);
      r21_q  <= mul30(sin_i[0], cos_i[1]);
      r22_q  <= mul30(cos_i[0], cos_i[1]);
      cxsz_q <= mul30(cos_i[0], sin_i[2]);
      sxsz_q <= mul30(sin_i[0], sin_i[2]);
      cxcz_q <= mul30(cos_i[0], cos_i[2]);
      sxcz_q <= mul30(sin_i[0], cos_i[2]);
      cz_q   <= cos_i[2];
      sz_q   <= sin_i[2];
      r20_q  <= -sin_i[1];
    end
  end

  // second products and sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q[0] <= r00_q;
      rot_q[1] <= mul30(sxsy_q, cz_q) - cxsz_q;
      rot_q[2] <= mul30(cxsy_q, cz_q) + sxsz_q;
      rot_q[3] <= r10_q;
      rot_q[4] <= mul30(sxsy_q, sz_q) + cxcz_q;
      rot_q[5] <= mul30(cxsy_q, sz_q) - sxcz_q;
      rot_q[6] <= r20_q;
      rot_q[7] <= r21_q;
      rot_q[8] <= r22_q;
    end
  end

  assign rot_o = rot_q;
endmodule

// ===== rtl/core/affine_transform_matrix_builder.sv =====
// Affine transform matrix builder: scale, Euler XYZ rotation, translation -> 4x4 Q16.16.
// Input channel s_axis: one item per matrix. tuser is the opcode (0 position T*R*S,
//   1 direction R*inv(S)); tdata holds scales (Q8.8), angles (Q3.13 rad), shifts (Q16.16).
// Output channel m_axis: four items per matrix, rows 0..3 in order; tlast marks row 3,
//   tuser is the zero-scale flag (direction mode only), tdata holds row index and elements.
// Datapath: angle fold, a row of CORDIC_STEPS cells per angle (one iteration each),
//   sign fix, two multiply stages for R, a scale stage, then a row of 29 restoring
//   divider cells (one quotient bit each) per element, then a row serializer.
// Rows follow one per cycle while m_axis_tready is high.
// Throughput: the sustained rate is set by the four-row serializer; the pipeline takes a
//   new item every cycle while its last stage is empty or the serializer takes from it.
// Stall: the whole pipeline holds when its last stage is full and the serializer is
//   busy; s_axis_tready then drops. A row waiting on m_axis holds its data.
// Reset (rst_ni low, async): all valid bits clear, no output, no clearing pass.
`timescale 1ns / 1ps
module affine_transform_matrix_builder #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
  input  logic [191:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_index, elem_0, elem_1, elem_2, elem_3, zero pad
  output logic [135:0] m_axis_tdata,
  // last_row
  output logic         m_axis_tlast,
  // zero_scale
  output logic         m_axis_tuser
);
  import atmb_pkg::*;

  localparam int NS = CORDIC_STEPS;

  logic en, acc;

  // ---------------- angle fold ----------------
  q30_t  fz_d [3];
  q30_t  fz_q [3];
  cpay_t fpay_d, fpay_q;
  logic  fv_q;

  always_comb begin
    logic signed [15:0] ang;
    logic signed [34:0] zt;
    fpay_d.opcode = s_axis_tuser;
    for (int l = 0; l < 3; l++) begin
      fpay_d.sc[l] = s_axis_tdata[16*l +: 16];
      fpay_d.sh[l] = s_axis_tdata[96+32*l +: 32];
      ang = $signed(s_axis_tdata[48+16*l +: 16]);
      zt  = {{2{ang[15]}}, ang, 17'b0};
      fpay_d.neg[l] = 1'b0;
      // fold into [-pi/2, pi/2]; sine and cosine change sign
      if (zt > HALF_PI_Q30) begin
        zt = zt - PI_Q30;
        fpay_d.neg[l] = 1'b1;
      end else if (zt < -HALF_PI_Q30) begin
        zt = zt + PI_Q30;
        fpay_d.neg[l] = 1'b1;
      end
      fz_d[l] = zt[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en) begin
      fv_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fz_q   <= fz_d;
      fpay_q <= fpay_d;
    end
  end

  // ---------------- CORDIC cell rows ----------------
  q30_t  cx [3][NS+1];
  q30_t  cy [3][NS+1];
  q30_t  cz [3][NS+1];
  // cp[k] and cv[k] sit beside cell output k+1
  cpay_t cp [NS];
  logic  cv [NS];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign cx[l][0] = GAIN_Q30;
    assign cy[l][0] = '0;
    assign cz[l][0] = fz_q[l];
    for (genvar k = 0; k < NS; k++) begin : g_step
      atmb_cordic_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (cx[l][k]),
        .y_i   (cy[l][k]),
        .z_i   (cz[l][k]),
        .x_o   (cx[l][k+1]),
        .y_o   (cy[l][k+1]),
        .z_o   (cz[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) cv[k] <= 1'b0;
    end else if (en) begin
      cv[0] <= fv_q;
      for (int k = 1; k < NS; k++) cv[k] <= cv[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp[0] <= fpay_q;
      for (int k = 1; k < NS; k++) cp[k] <= cp[k-1];
    end
  end

  // ---------------- sign fix ----------------
  q30_t  sn_q [3];
  q30_t  cn_q [3];
  cpay_t npay_q;
  logic  nv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sn_q[l] <= cp[NS-1].neg[l] ? -cy[l][NS] : cy[l][NS];
        cn_q[l] <= cp[NS-1].neg[l] ? -cx[l][NS] : cx[l][NS];
      end
      npay_q <= cp[NS-1];
    end
  end

  // ---------------- rotation matrix (two stages) ----------------
  q30_t  rot [9];
  cpay_t rpay1_q, rpay2_q;
  logic  nv_rst_q, rv1_q;

  atmb_rot u_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .sin_i (sn_q),
    .cos_i (cn_q),
    .rot_o (rot)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rpay1_q <= npay_q;
      rpay2_q <= rpay1_q;
    end
  end

  // ---------------- scale stage ----------------
  dpay_t              mpay_d, mpay_q;
  logic [DW-1:0]      mnum_d [9];
  logic [DW-1:0]      mnum_q [9];
  logic [SW-1:0]      mden_d [3];
  logic [SW-1:0]      mden_q [3];
  logic               mv_q;

  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [49:0]   p;
    logic [QW-1:0]        absr;
    logic [34:0]          num;
    q30_t                 r;
    mpay_d.dir = rpay2_q.opcode;
    mpay_d.sh  = rpay2_q.sh;
    for (int j = 0; j < 3; j++) begin
      s            = $signed(rpay2_q.sc[j]);
      mden_d[j]    = s[SW-1] ? SW'(-s) : s;
      mpay_d.szero[j] = (s == '0);
    end
    for (int e = 0; e < 9; e++) begin
      r    = rot[e];
      s    = $signed(rpay2_q.sc[e%3]);
      p    = r * s;
      p    = p + 50'sd2097152;
      mpay_d.pos[e] = {{4{p[49]}}, p[49:22]};
      absr = r[QW-1] ? QW'(-r) : r;
      // n + d/2 with d = |s|*64, then the /64 is taken off before dividing by |s|
      num  = 35'(absr) + 35'({mden_d[e%3], 5'b0});
      mnum_d[e]      = num[34:6];
      mpay_d.sgn[e]  = r[QW-1] ^ s[SW-1];
      mpay_d.rneg[e] = r[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mpay_q <= mpay_d;
      mnum_q <= mnum_d;
      mden_q <= mden_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_rst_q <= 1'b0;
      rv1_q    <= 1'b0;
      mv_q     <= 1'b0;
      nv_q     <= 1'b0;
    end else if (en) begin
      nv_q     <= cv[NS-1];
      nv_rst_q <= nv_q;
      rv1_q    <= nv_rst_q;
      mv_q     <= rv1_q;
    end
  end

  // ---------------- divider cell rows ----------------
  logic [SW-1:0] drem [9][DW+1];
  logic [DW-1:0] dw   [9][DW+1];
  logic [SW-1:0] dd   [9][DW+1];
  // dp[b] and dv[b] sit beside divider output b+1
  dpay_t         dp   [DW];
  logic          dv   [DW];

  for (genvar e = 0; e < 9; e++) begin : g_div
    assign drem[e][0] = '0;
    assign dw[e][0]   = mnum_q[e];
    assign dd[e][0]   = mden_q[e%3];
    for (genvar b = 0; b < DW; b++) begin : g_bit
      atmb_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (drem[e][b]),
        .w_i   (dw[e][b]),
        .d_i   (dd[e][b]),
        .rem_o (drem[e][b+1]),
        .w_o   (dw[e][b+1]),
        .d_o   (dd[e][b+1])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < DW; b++) dv[b] <= 1'b0;
    end else if (en) begin
      dv[0] <= mv_q;
      for (int b = 1; b < DW; b++) dv[b] <= dv[b-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp[0] <= mpay_q;
      for (int b = 1; b < DW; b++) dp[b] <= dp[b-1];
    end
  end

  // ---------------- element select ----------------
  logic [31:0] mat_d [3][4];
  logic        zf_d;

  always_comb begin
    logic [31:0] qv;
    dpay_t       fp;
    fp   = dp[DW-1];
    zf_d = fp.dir && (fp.szero != '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        qv = {3'b0, dw[3*i+j][DW]};
        if (!fp.dir) begin
          mat_d[i][j] = fp.pos[3*i+j];
        end else if (fp.szero[j]) begin
          mat_d[i][j] = fp.rneg[3*i+j] ? SAT_NEG : SAT_POS;
        end else begin
          mat_d[i][j] = fp.sgn[3*i+j] ? -qv : qv;
        end
      end
      mat_d[i][3] = fp.dir ? '0 : fp.sh[i];
    end
  end

  // ---------------- row serializer ----------------
  logic [31:0] mat_q [3][4];
  logic        zf_q;
  logic        ser_v_d, ser_v_q;
  logic [1:0]  row_d, row_q;
  logic        fin, take, load;

  assign fin  = ser_v_q && m_axis_tready && (row_q == ROW_LAST);
  assign take = !ser_v_q || fin;
  assign load = take && dv[DW-1];
  assign en   = !dv[DW-1] || take;
  assign acc  = s_axis_tvalid && en;

  always_comb begin
    ser_v_d = ser_v_q;
    row_d   = row_q;
    if (take) begin
      ser_v_d = dv[DW-1];
      row_d   = '0;
    end else if (m_axis_tready) begin
      row_d   = row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      row_q   <= '0;
    end else begin
      ser_v_q <= ser_v_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= mat_d;
      zf_q  <= zf_d;
    end
  end

  logic [31:0] e0, e1, e2, e3;

  always_comb begin
    if (row_q == ROW_LAST) begin
      e0 = '0;
      e1 = '0;
      e2 = '0;
      e3 = ONE_Q16;
    end else begin
      e0 = mat_q[row_q][0];
      e1 = mat_q[row_q][1];
      e2 = mat_q[row_q][2];
      e3 = mat_q[row_q][3];
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = ser_v_q;
  assign m_axis_tdata  = {6'b0, e3, e2, e1, e0, row_q};
  assign m_axis_tlast  = (row_q == ROW_LAST);
  assign m_axis_tuser  = zf_q;
endmodule

// ===== rtl/core/atmb_checker.sv =====
`timescale 1ns / 1ps
`include "affine_transform_matrix_builder_assert.svh"
module atmb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser
);
  // tlast marks row 3 and nothing else
  `ATMB_ASSERT_NOW(a_last_row, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[1:0] == 2'd3))

  // bottom row is always 0 0 0 1.0
  `ATMB_ASSERT_NOW(a_bottom_row, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[97:2] == 96'd0) && (m_axis_tdata[129:98] == 32'd65536))

  // rows of one matrix come back to back in order
  `ATMB_ASSERT_NEXT(a_row_order, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))

  // a stalled item holds
  `ATMB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind affine_transform_matrix_builder atmb_checker u_atmb_checker (.*);
